// ===== rtl/core/rspd_pkg.sv =====
// Shared constants, codes and helper functions for the remote serial packet deframer.
// Has no dependencies; every other file refers to it by scoped names.
package rspd_pkg;

  localparam int MAX_PACKET_LEN = 1024;
  localparam int LEN_W = $clog2(MAX_PACKET_LEN + 1);
  localparam int PKT_LEN_W = 11;

  localparam logic [7:0] CH_PLUS = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_HASH = 8'h23;

  localparam logic [2:0] PH_IDLE = 3'd0;
  localparam logic [2:0] PH_DISCARD = 3'd1;
  localparam logic [2:0] PH_DATA = 3'd2;
  localparam logic [2:0] PH_CK1 = 3'd3;
  localparam logic [2:0] PH_CK2 = 3'd4;

  localparam logic [2:0] EV_DATA = 3'd0;
  localparam logic [2:0] EV_GOOD = 3'd1;
  localparam logic [2:0] EV_MISMATCH = 3'd2;
  localparam logic [2:0] EV_SYNTAX = 3'd3;
  localparam logic [2:0] EV_FRAMING = 3'd4;
  localparam logic [2:0] EV_ACK = 3'd5;
  localparam logic [2:0] EV_NACK = 3'd6;
  localparam logic [2:0] EV_OVERFLOW = 3'd7;

  typedef struct packed {
    logic       ok;
    logic [3:0] value;
  } hex_t;

  function automatic hex_t hex_decode(input logic [7:0] b);
    hex_t h;
    h.ok = 1'b1;
    h.value = 4'd0;
    if (b >= 8'h30 && b <= 8'h39) begin
      h.value = 4'(b - 8'h30);
    end else if (b >= 8'h61 && b <= 8'h66) begin
      h.value = 4'(b - 8'h57);
    end else if (b >= 8'h41 && b <= 8'h46) begin
      h.value = 4'(b - 8'h37);
    end else begin
      h.ok = 1'b0;
    end
    return h;
  endfunction

endpackage

// ===== rtl/core/remote_serial_packet_deframer.sv =====
// Top level of the remote serial packet deframer: input beat register, framing state
// update and result register. Depends on rspd_pkg.
// Results are registered: a beat taken into the input register updates the framing
// state, and any result waits in the result register while out_stall holds it.
// Throughput: one input beat per cycle while out_stall holds no result; the one-beat
// input register still takes a new beat while a finished result waits on out_stall.
// Reset: synchronous, active low; it empties both registers and returns the framing
// state to idle with a zero sum, length and checksum digit.
module remote_serial_packet_deframer (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [7:0]                   in_rx_byte,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [2:0]                   out_event_res,
  output logic [7:0]                   out_data_byte,
  output logic [rspd_pkg::PKT_LEN_W-1:0] out_packet_length,
  output logic [7:0]                   out_computed_sum
);

  logic                       s1_valid_r;
  logic [7:0]                 s1_byte_r;
  logic                       adv;

  logic [2:0]                 phase_r, phase_nxt;
  logic [7:0]                 sum_r, sum_nxt;
  logic [rspd_pkg::LEN_W-1:0] len_r, len_nxt;
  logic [3:0]                 nib_r, nib_nxt;
  logic                       nib_ok_r, nib_ok_nxt;

  logic                       res;
  logic [2:0]                 ev;
  logic [7:0]                 data;
  logic                       carry_stats;
  rspd_pkg::hex_t             hx;
  logic [7:0]                 ck_value;

  logic                       out_valid_r;
  logic [2:0]                 ev_r;
  logic [7:0]                 data_r;
  logic [rspd_pkg::PKT_LEN_W-1:0] plen_r;
  logic [7:0]                 csum_r;

  assign adv = !out_valid_r || !out_stall;
  assign in_stall = s1_valid_r && !adv;

  always_comb begin
    phase_nxt = phase_r;
    sum_nxt = sum_r;
    len_nxt = len_r;
    nib_nxt = nib_r;
    nib_ok_nxt = nib_ok_r;
    res = 1'b0;
    ev = rspd_pkg::EV_DATA;
    data = 8'd0;
    carry_stats = 1'b0;
    hx = rspd_pkg::hex_decode(s1_byte_r);
    ck_value = hx.ok ? {nib_r, hx.value} : {4'd0, nib_r};
    unique case (phase_r)
      rspd_pkg::PH_DISCARD: begin
        if (s1_byte_r == rspd_pkg::CH_DOLLAR) begin
          phase_nxt = rspd_pkg::PH_DATA;
          sum_nxt = 8'd0;
          len_nxt = '0;
          nib_nxt = 4'd0;
          nib_ok_nxt = 1'b0;
        end
      end
      rspd_pkg::PH_DATA: begin
        if (s1_byte_r == rspd_pkg::CH_HASH) begin
          phase_nxt = rspd_pkg::PH_CK1;
        end else if (len_r >= rspd_pkg::LEN_W'(rspd_pkg::MAX_PACKET_LEN)) begin
          res = 1'b1;
          ev = rspd_pkg::EV_OVERFLOW;
          carry_stats = 1'b1;
          phase_nxt = rspd_pkg::PH_DISCARD;
        end else begin
          res = 1'b1;
          ev = rspd_pkg::EV_DATA;
          data = s1_byte_r;
          sum_nxt = sum_r + s1_byte_r;
          len_nxt = len_r + 1'b1;
        end
      end
      rspd_pkg::PH_CK1: begin
        phase_nxt = rspd_pkg::PH_CK2;
        if (hx.ok) begin
          nib_nxt = hx.value;
          nib_ok_nxt = 1'b1;
        end else begin
          nib_nxt = 4'd0;
          nib_ok_nxt = 1'b0;
          res = 1'b1;
          ev = rspd_pkg::EV_SYNTAX;
          carry_stats = 1'b1;
        end
      end
      rspd_pkg::PH_CK2: begin
        phase_nxt = rspd_pkg::PH_IDLE;
        if (nib_ok_r) begin
          nib_ok_nxt = 1'b0;
          res = 1'b1;
          carry_stats = 1'b1;
          ev = (ck_value == sum_r) ? rspd_pkg::EV_GOOD : rspd_pkg::EV_MISMATCH;
        end
      end
      default: begin
        phase_nxt = rspd_pkg::PH_IDLE;
        if (s1_byte_r == rspd_pkg::CH_PLUS) begin
          res = 1'b1;
          ev = rspd_pkg::EV_ACK;
        end else if (s1_byte_r == rspd_pkg::CH_MINUS) begin
          res = 1'b1;
          ev = rspd_pkg::EV_NACK;
        end else if (s1_byte_r == rspd_pkg::CH_DOLLAR) begin
          phase_nxt = rspd_pkg::PH_DATA;
          sum_nxt = 8'd0;
          len_nxt = '0;
          nib_nxt = 4'd0;
          nib_ok_nxt = 1'b0;
        end else begin
          res = 1'b1;
          ev = rspd_pkg::EV_FRAMING;
          phase_nxt = rspd_pkg::PH_DISCARD;
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!s1_valid_r || adv) begin
      s1_valid_r <= in_valid;
    end
    if ((!s1_valid_r || adv) && in_valid) begin
      s1_byte_r <= in_rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= rspd_pkg::PH_IDLE;
      sum_r <= 8'd0;
      len_r <= '0;
      nib_r <= 4'd0;
      nib_ok_r <= 1'b0;
    end else if (s1_valid_r && adv) begin
      phase_r <= phase_nxt;
      sum_r <= sum_nxt;
      len_r <= len_nxt;
      nib_r <= nib_nxt;
      nib_ok_r <= nib_ok_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= s1_valid_r && res;
    end
    if (adv && s1_valid_r && res) begin
      ev_r <= ev;
      data_r <= data;
      plen_r <= carry_stats ? rspd_pkg::PKT_LEN_W'(len_r) : '0;
      csum_r <= carry_stats ? sum_r : 8'd0;
    end
  end

  assign out_valid = out_valid_r;
  assign out_event_res = ev_r;
  assign out_data_byte = data_r;
  assign out_packet_length = plen_r;
  assign out_computed_sum = csum_r;

endmodule
